@@ sv/nnds_pkg.sv @@
// nnds_pkg: shared types and constants for the nearest neighbor downscaler
// pixel and result transaction structs, register indexes, reset sizes
// no dependencies

package nnds_pkg;

    localparam int CFG_DATA_W = 13;
    localparam int CFG_INDEX_W = 8;
    localparam int COORD_W = 12;
    localparam int CFG_MAX = (1 << CFG_DATA_W) - 1;

    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_WIDTH  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_HEIGHT = 8'd3;

    localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 13'd128;
    localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 13'd85;

    typedef struct packed {
        logic [7:0] pix_blue;
        logic [7:0] pix_green;
        logic [7:0] pix_red;
    } pix_t;

    typedef struct packed {
        logic [7:0]         out_blue;
        logic [7:0]         out_green;
        logic [7:0]         out_red;
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic               frame_last;
    } res_t;

endpackage

@@ sv/nearest_neighbor_downscaler.sv @@
// nearest_neighbor_downscaler: streaming nearest neighbor image downscaler
// top level with size registers, shared restoring divider and position tracking
// depends on nnds_pkg
//
// source pixels enter on the pix channel in raster order, one transaction per
// pixel; selected pixels leave on the res channel with output row, column and
// an end-of-frame flag. pixels that are not selected produce no result.
// a selected pixel appears on res in the cycle after its pix transaction, and a
// new pixel is taken every cycle while the result register is free or being
// drained in the same cycle, so the sustained rate is one pixel per clock.
// if the receiver stalls, the result register holds and pix_ready drops until
// the pending result is taken.
// cfg writes sizes by register index (0 source width, 1 source height,
// 2 target width, 3 target height); a write to a known index restarts the
// frame. after reset and after each such write, a shared restoring divider
// computes width and height step quotients, one quotient bit per cycle;
// pix_ready stays low until both quotients are done.
// reset loads 128 x 85 for both source and target sizes.

module nearest_neighbor_downscaler
    import nnds_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   pix_valid,
    output logic                   pix_ready,
    input  pix_t                   pix,
    output logic                   res_valid,
    input  logic                   res_ready,
    output res_t                   res
);

    localparam int EFF_MAX = (MAX_DIM < CFG_MAX) ? MAX_DIM : CFG_MAX;
    localparam int DW = $clog2(EFF_MAX + 1);
    localparam int CNT_W = (DW > 1) ? $clog2(DW) : 1;

    typedef enum logic [2:0] {
        DIV_LOAD_COL,
        DIV_RUN_COL,
        DIV_LOAD_ROW,
        DIV_RUN_ROW,
        DIV_DONE
    } div_state_t;

    function automatic logic [DW-1:0] eff_dim(input logic [CFG_DATA_W-1:0] v);
        logic [DW-1:0] r;
        if (v == '0)
            r = DW'(1);
        else if (32'(v) > MAX_DIM)
            r = DW'(MAX_DIM);
        else
            r = DW'(v);
        return r;
    endfunction

    // size registers
    logic [CFG_DATA_W-1:0] src_w_cfg_reg, src_h_cfg_reg, dst_w_cfg_reg, dst_h_cfg_reg;
    logic                  cfg_write;
    logic                  cfg_known;

    // effective sizes
    logic [DW-1:0] sw, sh, tw_raw, th_raw, tw, th;

    // divider
    div_state_t    div_state_reg;
    logic [DW-1:0] div_rem_reg;
    logic [DW-1:0] div_quo_reg;
    logic [CNT_W-1:0] div_cnt_reg;
    logic [DW-1:0] div_den;
    logic [DW:0]   div_shift;
    logic          div_ge;
    logic [DW:0]   div_diff;
    logic [DW-1:0] div_rem_next;
    logic [DW-1:0] div_quo_next;
    logic [DW-1:0] col_q_reg, col_r_reg, row_q_reg, row_r_reg;

    // position
    logic [DW-1:0] src_row_reg, src_col_reg, dst_row_reg, dst_col_reg;
    logic [DW-1:0] nsr_reg, nsc_reg, row_rem_reg, col_rem_reg;
    logic [DW-1:0] src_row_next, src_col_next, dst_row_next, dst_col_next;
    logic [DW-1:0] nsr_next, nsc_next, row_rem_next, col_rem_next;
    logic          row_hit, hit, col_end, row_end, last;
    logic [DW:0]   col_sum, row_sum, col_tgt, row_tgt;
    logic          col_wrap, row_wrap;
    logic [DW:0]   col_inc, row_inc;

    // output
    logic pix_accept;
    logic res_valid_reg;
    res_t res_reg;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        unique case (cfg_index)
            REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT,
            REG_TARGET_WIDTH, REG_TARGET_HEIGHT: cfg_known = 1'b1;
            default:                             cfg_known = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_cfg_reg <= RESET_WIDTH;
            src_h_cfg_reg <= RESET_HEIGHT;
            dst_w_cfg_reg <= RESET_WIDTH;
            dst_h_cfg_reg <= RESET_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH:  src_w_cfg_reg <= cfg_data;
                REG_SOURCE_HEIGHT: src_h_cfg_reg <= cfg_data;
                REG_TARGET_WIDTH:  dst_w_cfg_reg <= cfg_data;
                REG_TARGET_HEIGHT: dst_h_cfg_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        sw     = eff_dim(src_w_cfg_reg);
        sh     = eff_dim(src_h_cfg_reg);
        tw_raw = eff_dim(dst_w_cfg_reg);
        th_raw = eff_dim(dst_h_cfg_reg);
        tw     = (tw_raw > sw) ? sw : tw_raw;
        th     = (th_raw > sh) ? sh : th_raw;
    end

    // restoring divider step, one quotient bit per cycle
    always_comb
    begin
        div_den      = (div_state_reg == DIV_RUN_ROW) ? th : tw;
        div_shift    = {div_rem_reg, div_quo_reg[DW-1]};
        div_ge       = div_shift >= {1'b0, div_den};
        div_diff     = div_shift - {1'b0, div_den};
        div_rem_next = div_ge ? div_diff[DW-1:0] : div_shift[DW-1:0];
        div_quo_next = {div_quo_reg[DW-2:0], div_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_state_reg <= DIV_LOAD_COL;
            div_cnt_reg   <= '0;
            div_rem_reg   <= '0;
            div_quo_reg   <= '0;
            col_q_reg     <= '0;
            col_r_reg     <= '0;
            row_q_reg     <= '0;
            row_r_reg     <= '0;
        end
        else if (cfg_write && cfg_known)
        begin
            div_state_reg <= DIV_LOAD_COL;
        end
        else
        begin
            unique case (div_state_reg)
                DIV_LOAD_COL, DIV_LOAD_ROW:
                begin
                    div_rem_reg   <= '0;
                    div_quo_reg   <= (div_state_reg == DIV_LOAD_COL) ? sw : sh;
                    div_cnt_reg   <= '0;
                    div_state_reg <= (div_state_reg == DIV_LOAD_COL) ? DIV_RUN_COL
                                                                     : DIV_RUN_ROW;
                end
                DIV_RUN_COL, DIV_RUN_ROW:
                begin
                    div_rem_reg <= div_rem_next;
                    div_quo_reg <= div_quo_next;
                    div_cnt_reg <= div_cnt_reg + CNT_W'(1);
                    if (div_cnt_reg == CNT_W'(DW - 1))
                    begin
                        if (div_state_reg == DIV_RUN_COL)
                        begin
                            col_q_reg     <= div_quo_next;
                            col_r_reg     <= div_rem_next;
                            div_state_reg <= DIV_LOAD_ROW;
                        end
                        else
                        begin
                            row_q_reg     <= div_quo_next;
                            row_r_reg     <= div_rem_next;
                            div_state_reg <= DIV_DONE;
                        end
                    end
                end
                DIV_DONE: ;
                default:  div_state_reg <= DIV_LOAD_COL;
            endcase
        end
    end

    assign pix_ready  = (div_state_reg == DIV_DONE) && (!res_valid_reg || res_ready);
    assign pix_accept = pix_valid && pix_ready;

    // selection and incremental target tracking
    always_comb
    begin
        row_hit = (src_row_reg == nsr_reg) && (dst_row_reg < th);
        hit     = row_hit && (src_col_reg == nsc_reg) && (dst_col_reg < tw);
        col_end = ({1'b0, src_col_reg} + (DW+1)'(1)) >= {1'b0, sw};
        row_end = ({1'b0, src_row_reg} + (DW+1)'(1)) >= {1'b0, sh};
        last    = (dst_row_reg == th - DW'(1)) && (dst_col_reg == tw - DW'(1));

        col_sum  = {1'b0, col_rem_reg} + {1'b0, col_r_reg};
        col_wrap = col_sum >= {1'b0, tw};
        col_inc  = {1'b0, nsc_reg} + {1'b0, col_q_reg};
        col_tgt  = col_inc + (DW+1)'(col_wrap);
        row_sum  = {1'b0, row_rem_reg} + {1'b0, row_r_reg};
        row_wrap = row_sum >= {1'b0, th};
        row_inc  = {1'b0, nsr_reg} + {1'b0, row_q_reg};
        row_tgt  = row_inc + (DW+1)'(row_wrap);

        src_row_next = src_row_reg;
        src_col_next = src_col_reg;
        dst_row_next = dst_row_reg;
        dst_col_next = dst_col_reg;
        nsr_next     = nsr_reg;
        nsc_next     = nsc_reg;
        row_rem_next = row_rem_reg;
        col_rem_next = col_rem_reg;

        if (col_end)
        begin
            src_col_next = '0;
            dst_col_next = '0;
            nsc_next     = '0;
            col_rem_next = '0;
            if (row_hit)
            begin
                dst_row_next = dst_row_reg + DW'(1);
                nsr_next     = row_tgt[DW-1:0];
                row_rem_next = row_wrap ? DW'(row_sum - {1'b0, th}) : row_sum[DW-1:0];
            end
            if (row_end)
            begin
                src_row_next = '0;
                dst_row_next = '0;
                nsr_next     = '0;
                row_rem_next = '0;
            end
            else
            begin
                src_row_next = src_row_reg + DW'(1);
            end
        end
        else
        begin
            src_col_next = src_col_reg + DW'(1);
            if (hit)
            begin
                dst_col_next = dst_col_reg + DW'(1);
                nsc_next     = col_tgt[DW-1:0];
                col_rem_next = col_wrap ? DW'(col_sum - {1'b0, tw}) : col_sum[DW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_row_reg <= '0;
            src_col_reg <= '0;
            dst_row_reg <= '0;
            dst_col_reg <= '0;
            nsr_reg     <= '0;
            nsc_reg     <= '0;
            row_rem_reg <= '0;
            col_rem_reg <= '0;
        end
        else if (cfg_write && cfg_known)
        begin
            src_row_reg <= '0;
            src_col_reg <= '0;
            dst_row_reg <= '0;
            dst_col_reg <= '0;
            nsr_reg     <= '0;
            nsc_reg     <= '0;
            row_rem_reg <= '0;
            col_rem_reg <= '0;
        end
        else if (pix_accept)
        begin
            src_row_reg <= src_row_next;
            src_col_reg <= src_col_next;
            dst_row_reg <= dst_row_next;
            dst_col_reg <= dst_col_next;
            nsr_reg     <= nsr_next;
            nsc_reg     <= nsc_next;
            row_rem_reg <= row_rem_next;
            col_rem_reg <= col_rem_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (pix_accept)
            res_valid_reg <= hit;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept && hit)
        begin
            res_reg.out_blue   <= pix.pix_blue;
            res_reg.out_green  <= pix.pix_green;
            res_reg.out_red    <= pix.pix_red;
            res_reg.out_row    <= COORD_W'(dst_row_reg);
            res_reg.out_col    <= COORD_W'(dst_col_reg);
            res_reg.frame_last <= last;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

// testbench: self-checking bench for nearest_neighbor_downscaler
// streams raster pixels over many size settings and checks every output transaction
// depends on nnds_pkg and nearest_neighbor_downscaler

module testbench;
    import nnds_pkg::*;

    localparam int MAX_DIM = 4096;
    localparam logic [CFG_DATA_W-1:0] DIM_LIMIT = CFG_DATA_W'(MAX_DIM);
    localparam logic [CFG_DATA_W-1:0] CFG_ALL_ONES = CFG_DATA_W'(CFG_MAX);
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_LIMIT = 10;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LOW = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HIGH = 8'hFF;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic pix_valid;
    logic pix_ready;
    pix_t pix;
    logic res_valid;
    logic res_ready;
    res_t res;

    // size registers and frame position as the scaler should hold them
    logic [CFG_DATA_W-1:0] src_w_reg;
    logic [CFG_DATA_W-1:0] src_h_reg;
    logic [CFG_DATA_W-1:0] dst_w_reg;
    logic [CFG_DATA_W-1:0] dst_h_reg;
    logic [CFG_DATA_W-1:0] src_row;
    logic [CFG_DATA_W-1:0] src_col;
    logic [CFG_DATA_W-1:0] out_row_next;
    logic [CFG_DATA_W-1:0] out_col_next;
    logic [CFG_DATA_W-1:0] pick_row;
    logic [CFG_DATA_W-1:0] pick_col;
    logic [CFG_DATA_W-1:0] row_frac;
    logic [CFG_DATA_W-1:0] col_frac;

    res_t pending_outputs[$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int hold_left;
    int cycle_count;
    int mismatch_count;
    int pixels_sent;
    int outputs_checked;
    int reg_writes;

    nearest_neighbor_downscaler #(
        .MAX_DIM(MAX_DIM)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pix_valid(pix_valid),
        .pix_ready(pix_ready),
        .pix(pix),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [CFG_DATA_W-1:0] eff_size(input logic [CFG_DATA_W-1:0] v);
        if (v == 0)
            return CFG_DATA_W'(1);
        if (v > DIM_LIMIT)
            return DIM_LIMIT;
        return v;
    endfunction

    function automatic void restart_position();
        src_row = '0;
        src_col = '0;
        out_row_next = '0;
        out_col_next = '0;
        pick_row = '0;
        pick_col = '0;
        row_frac = '0;
        col_frac = '0;
    endfunction

    function automatic void step_target(inout logic [CFG_DATA_W-1:0] pos,
                                        inout logic [CFG_DATA_W-1:0] frac,
                                        input logic [CFG_DATA_W-1:0] num,
                                        input logic [CFG_DATA_W-1:0] den);
        pos = pos + num / den;
        frac = frac + num % den;
        if (frac >= den)
        begin
            frac = frac - den;
            pos = pos + 1'b1;
        end
    endfunction

    function automatic void apply_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SOURCE_WIDTH:  src_w_reg = data;
            REG_SOURCE_HEIGHT: src_h_reg = data;
            REG_TARGET_WIDTH:  dst_w_reg = data;
            REG_TARGET_HEIGHT: dst_h_reg = data;
            default: return;
        endcase
        restart_position();
    endfunction

    // returns 1 when the arriving pixel is copied to the output frame
    function automatic bit scale_pixel(input pix_t p, output res_t r);
        logic [CFG_DATA_W-1:0] sw;
        logic [CFG_DATA_W-1:0] sh;
        logic [CFG_DATA_W-1:0] tw;
        logic [CFG_DATA_W-1:0] th;
        bit row_sel;
        bit col_sel;
        sw = eff_size(src_w_reg);
        sh = eff_size(src_h_reg);
        tw = eff_size(dst_w_reg);
        th = eff_size(dst_h_reg);
        if (tw > sw)
            tw = sw;
        if (th > sh)
            th = sh;
        row_sel = (src_row == pick_row) && (out_row_next < th);
        col_sel = row_sel && (src_col == pick_col) && (out_col_next < tw);
        r = '0;
        if (col_sel)
        begin
            r.out_blue = p.pix_blue;
            r.out_green = p.pix_green;
            r.out_red = p.pix_red;
            r.out_row = out_row_next[COORD_W-1:0];
            r.out_col = out_col_next[COORD_W-1:0];
            r.frame_last = (out_row_next == th - 1'b1) && (out_col_next == tw - 1'b1);
            out_col_next = out_col_next + 1'b1;
            step_target(pick_col, col_frac, sw, tw);
        end
        if (src_col + 1 >= sw)
        begin
            src_col = '0;
            out_col_next = '0;
            pick_col = '0;
            col_frac = '0;
            if (row_sel)
            begin
                out_row_next = out_row_next + 1'b1;
                step_target(pick_row, row_frac, sh, th);
            end
            if (src_row + 1 >= sh)
                restart_position();
            else
                src_row = src_row + 1'b1;
        end
        else
            src_col = src_col + 1'b1;
        return col_sel;
    endfunction

    // one process checks outputs and predicts from accepted transactions
    always @(posedge clk)
    begin
        res_t want;
        res_t scaled;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (pending_outputs.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected output at cycle %0d: row %0d col %0d",
                                 cycle_count, res.out_row, res.out_col);
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    outputs_checked++;
                    if (res.out_blue !== want.out_blue || res.out_green !== want.out_green ||
                        res.out_red !== want.out_red || res.out_row !== want.out_row ||
                        res.out_col !== want.out_col || res.frame_last !== want.frame_last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"output mismatch at cycle %0d: expected bgr %h %h %h ",
                                      "row %0d col %0d last %b, got bgr %h %h %h ",
                                      "row %0d col %0d last %b"}, cycle_count,
                                     want.out_blue, want.out_green, want.out_red,
                                     want.out_row, want.out_col, want.frame_last,
                                     res.out_blue, res.out_green, res.out_red,
                                     res.out_row, res.out_col, res.frame_last);
                    end
                end
            end
            if (pix_valid && pix_ready)
            begin
                pixels_sent++;
                if (scale_pixel(pix, scaled))
                    pending_outputs.push_back(scaled);
            end
            if (cfg_valid && cfg_ready)
            begin
                reg_writes++;
                apply_reg_write(cfg_index, cfg_data);
            end
        end
    end

    // receiver: random stalls plus requested long hold-offs
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else
            res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d outputs outstanding",
                     cycle_count, pending_outputs.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic send_pixel(input pix_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            pix_valid <= 1'b0;
        end
        @(negedge clk);
        pix_valid <= 1'b1;
        pix <= p;
        do @(posedge clk); while (!pix_ready);
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_pixel(pix_t'(24'($urandom)));
    endtask

    task automatic drain_outputs();
        @(negedge clk);
        pix_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_sizes(input logic [CFG_DATA_W-1:0] sw, input logic [CFG_DATA_W-1:0] sh,
                             input logic [CFG_DATA_W-1:0] tw, input logic [CFG_DATA_W-1:0] th);
        drain_outputs();
        write_reg(REG_SOURCE_WIDTH, sw);
        write_reg(REG_SOURCE_HEIGHT, sh);
        write_reg(REG_TARGET_WIDTH, tw);
        write_reg(REG_TARGET_HEIGHT, th);
    endtask

    task automatic test_reset_sizes();
        set_idling(0, 0);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h555555);
        send_pixel(24'hAAAAAA);
        send_pixel(24'h0000FF);
        send_pixel(24'hFF0000);
    endtask

    task automatic test_size_rules();
        // zero sizes act as one pixel
        set_sizes(0, 0, 0, 0);
        send_random(2);
        // upscale request clamps to source size, unknown index keeps position
        set_sizes(5, 3, 9, 7);
        send_random(3);
        drain_outputs();
        write_reg(REG_UNUSED_LOW, 13'($urandom));
        write_reg(REG_UNUSED_HIGH, CFG_ALL_ONES);
        send_random(3);
        // width above the limit
        set_sizes(CFG_ALL_ONES, 2, 3, 1);
        send_random(3);
    endtask

    task automatic test_frame_wrap();
        set_sizes(3, 2, 2, 1);
        send_random(12);
    endtask

    task automatic test_coordinate_limits();
        set_sizes(CFG_ALL_ONES, 1, CFG_ALL_ONES, 1);
        send_random(64);
        set_sizes(1, CFG_ALL_ONES, 1, DIM_LIMIT);
        send_random(64);
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        set_sizes(4, 4, 4, 4);
        hold_request = 150;
        send_random(16);
        drain_outputs();
        send_random(8);
    endtask

    task automatic test_random_frames();
        int send_pcts[4] = '{0, 86, 0, 26};
        int recv_pcts[4] = '{0, 0, 86, 26};
        logic [CFG_DATA_W-1:0] sw;
        logic [CFG_DATA_W-1:0] sh;
        logic [CFG_DATA_W-1:0] tw;
        logic [CFG_DATA_W-1:0] th;
        for (int seg = 0; seg < 8; seg++)
        begin
            sw = CFG_DATA_W'($urandom_range(8, 1));
            sh = CFG_DATA_W'($urandom_range(5, 1));
            tw = CFG_DATA_W'($urandom_range(sw + 2, 1));
            th = CFG_DATA_W'($urandom_range(sh + 2, 1));
            if ($urandom_range(9) == 0)
                sw = 0;
            if ($urandom_range(9) == 0)
                sh = 0;
            if ($urandom_range(9) == 0)
                tw = 0;
            if ($urandom_range(9) == 0)
                th = 0;
            set_sizes(sw, sh, tw, th);
            set_idling(send_pcts[seg % 4], recv_pcts[seg % 4]);
            send_random(30);
            if ($urandom_range(2) == 0)
            begin
                drain_outputs();
                write_reg(8'($urandom_range(255, 4)), 13'($urandom));
            end
            send_random(14);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_SOURCE_WIDTH;
        cfg_data = '0;
        pix_valid = 1'b0;
        pix = '0;
        res_ready = 1'b0;
        hold_request = 0;
        hold_left = 0;
        cycle_count = 0;
        mismatch_count = 0;
        pixels_sent = 0;
        outputs_checked = 0;
        reg_writes = 0;
        set_idling(0, 0);
        src_w_reg = RESET_WIDTH;
        src_h_reg = RESET_HEIGHT;
        dst_w_reg = RESET_WIDTH;
        dst_h_reg = RESET_HEIGHT;
        restart_position();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_sizes();
        test_size_rules();
        test_frame_wrap();
        test_backpressure();
        test_coordinate_limits();
        test_random_frames();

        drain_outputs();
        repeat (10) @(posedge clk);
        if (pending_outputs.size() != 0)
            mismatch_count++;
        $display("run: %0d pixels, %0d outputs checked, %0d register writes, %0d mismatches",
                 pixels_sent, outputs_checked, reg_writes, mismatch_count);
        $display("sizes covered: reset, zero, clamped, upscale, oversize width and height, stalls");
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
